/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DqDepthDefault     = 16;
  localparam int unsigned DqDataWidthDefault = 32;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST_FWD   = 3'd4,
    OP_LIST_BWD   = 3'd5
  } dq_op_e;

  typedef enum logic [StatusWidth-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } dq_status_e;

endpackage

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words kept in a ring memory with front pointer and
// element count. Push/pop at both ends, listing in either direction.
// ----------------------------------------------------------------------------
// results: pops pass the memory read register, then the output register;
// pushes only the output register. Both wait while the master side stalls,
// and no new request is taken meanwhile. A listing holds the slave side, one
// word a cycle off the memory read port while the master side does not stall
// reset: queue empty, front pointer zero; memory contents are not cleared
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = DqDepthDefault,
  parameter int unsigned DATA_WIDTH = DqDataWidthDefault,
  localparam int unsigned TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned TUSER_IW  = 8,
  localparam int unsigned TUSER_OW  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TDATA_W-1:0]  s_axis_tdata,   // value
  input  logic [TUSER_IW-1:0] s_axis_tuser,   // opcode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata,   // data
  output logic [TUSER_OW-1:0] m_axis_tuser,   // status
  output logic                m_axis_tlast
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_LIST
  } state_e;

  state_e     state_q, state_d;
  logic [PTR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic [PTR_W-1:0] pos_q, pos_d;
  logic             back_q, back_d;
  logic             use_mem_q, use_mem_d;
  dq_status_e       stat_q, stat_d;

  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_data_q, out_data_d;
  dq_status_e            out_stat_q, out_stat_d;
  logic                  out_last_q, out_last_d;

  logic [DATA_WIDTH-1:0] word_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;

  logic             in_acc, out_free, is_full, is_empty;
  logic [DATA_WIDTH-1:0] in_value;
  dq_op_e           in_op;
  logic [SUM_W-1:0] tail_sum, rear_sum;
  logic [PTR_W-1:0] tail_idx, rear_idx, front_inc, front_dec, pos_next;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_op         = dq_op_e'(s_axis_tuser[OpWidth-1:0]);
  assign in_value      = s_axis_tdata[DATA_WIDTH-1:0];
  assign is_full       = (count_q == CNT_W'(DEPTH));
  assign is_empty      = (count_q == '0);

  // ring index arithmetic, one wrap correction each
  assign tail_sum  = SUM_W'(front_q) + SUM_W'(count_q);
  assign rear_sum  = tail_sum - SUM_W'(1);
  assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(tail_sum);
  assign rear_idx  = (rear_sum >= SUM_W'(DEPTH)) ? PTR_W'(rear_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(rear_sum);
  assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + PTR_W'(1);
  assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);

  always_comb begin
    if (back_q) begin
      pos_next = (pos_q == '0) ? PTR_W'(DEPTH - 1) : pos_q - PTR_W'(1);
    end else begin
      pos_next = (pos_q == PTR_W'(DEPTH - 1)) ? '0 : pos_q + PTR_W'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    left_d      = left_q;
    pos_d       = pos_q;
    back_d      = back_q;
    use_mem_d   = use_mem_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_idx;
    rd_en       = 1'b0;
    rd_addr     = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              use_mem_d = 1'b0;
              state_d   = S_RESP;
              if (is_full) begin
                stat_d = STAT_FULL;
              end else begin
                stat_d  = STAT_OK;
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (in_op == OP_PUSH_FRONT) begin
                  mem_waddr = front_dec;
                  front_d   = front_dec;
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              state_d = S_RESP;
              if (is_empty) begin
                stat_d    = STAT_EMPTY;
                use_mem_d = 1'b0;
              end else begin
                stat_d    = STAT_OK;
                use_mem_d = 1'b1;
                rd_en     = 1'b1;
                count_d   = count_q - CNT_W'(1);
                if (in_op == OP_POP_FRONT) begin
                  front_d = front_inc;
                end else begin
                  rd_addr = rear_idx;
                end
              end
            end
            OP_LIST_FWD, OP_LIST_BWD: begin
              if (is_empty) begin
                stat_d    = STAT_EMPTY;
                use_mem_d = 1'b0;
                state_d   = S_RESP;
              end else begin
                back_d  = (in_op == OP_LIST_BWD);
                rd_en   = 1'b1;
                rd_addr = (in_op == OP_LIST_BWD) ? rear_idx : front_q;
                pos_d   = rd_addr;
                left_d  = count_q;
                state_d = S_LIST;
              end
            end
            default: begin
              // undefined opcodes are taken and dropped
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_last_d  = 1'b1;
          if (use_mem_q) begin
            out_data_d = rd_q;
          end else if (stat_q == STAT_EMPTY) begin
            out_data_d = '1;
          end else begin
            out_data_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_q;
          out_stat_d  = STAT_OK;
          out_last_d  = (left_q == CNT_W'(1));
          if (left_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            // next word read overlaps the current one leaving
            rd_en   = 1'b1;
            rd_addr = pos_next;
            pos_d   = pos_next;
            left_d  = left_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      left_q      <= '0;
      pos_q       <= '0;
      back_q      <= 1'b0;
      use_mem_q   <= 1'b0;
      stat_q      <= STAT_OK;
      out_valid_q <= 1'b0;
      out_stat_q  <= STAT_OK;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      back_q      <= back_d;
      use_mem_q   <= use_mem_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      out_stat_q  <= out_stat_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      word_mem[mem_waddr] <= in_value;
    end
    if (rd_en) begin
      rd_q <= word_mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);
  assign m_axis_tuser  = TUSER_OW'(out_stat_q);
  assign m_axis_tlast  = out_last_q;

endmodule

/* dv/double_ended_queue_tb.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push, pop and listing requests into the deque over the slave stream
// and checks every word that comes back on the master stream against a
// ring-buffer predictor, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module double_ended_queue_tb
  import dq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth      = DqDepthDefault;
  localparam int DataW      = DqDataWidthDefault;
  localparam int TdataW     = ((DataW + 7) / 8) * 8;
  localparam int TuserW     = 8;
  localparam int RandItems  = 480;
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 250;
  localparam int SettleCyc  = 16;

  localparam logic [OpWidth-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OpWidth-1:0] OP_UNUSED_7 = 3'd7;
  localparam logic [DataW-1:0]   EmptyWord   = '1;

  typedef struct {
    logic [OpWidth-1:0]      op;
    logic signed [DataW-1:0] value;
    int                      gap;
    bit                      drain;
  } deque_req_t;

  typedef struct {
    logic signed [DataW-1:0] data;
    dq_status_e              status;
    logic                    last;
  } deque_word_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata  = '0;  // value
  logic [TuserW-1:0] s_axis_tuser  = '0;  // opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;        // data
  logic [TuserW-1:0] m_axis_tuser;        // status
  logic              m_axis_tlast;

  deque_req_t  request_queue[$];
  deque_word_t due_words[$];
  deque_req_t  active_req;

  // predictor state
  logic [DataW-1:0] ring_mem[Depth];
  int               ring_front = 0;
  int               ring_count = 0;

  int  idle_cnt       = 0;
  int  requests_taken = 0;
  int  rx_wait        = 0;
  bit  rx_eager       = 1'b0;
  bit  hold_off       = 1'b0;
  int  mismatch_cnt   = 0;

  double_ended_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1ns clk_i = ~clk_i;

  // advance the ring model by one request and queue the words it produces
  task automatic apply_request(input deque_req_t req);
    deque_word_t w;
    int          off;
    w.data   = '0;
    w.status = STAT_OK;
    w.last   = 1'b1;
    case (req.op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (ring_count >= Depth) begin
          w.status = STAT_FULL;
        end else begin
          if (req.op == OP_PUSH_FRONT) begin
            ring_front = (ring_front + Depth - 1) % Depth;
            ring_mem[ring_front] = req.value;
          end else begin
            ring_mem[(ring_front + ring_count) % Depth] = req.value;
          end
          ring_count++;
        end
        due_words.push_back(w);
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (ring_count == 0) begin
          w.data   = EmptyWord;
          w.status = STAT_EMPTY;
        end else if (req.op == OP_POP_FRONT) begin
          w.data     = ring_mem[ring_front];
          ring_front = (ring_front + 1) % Depth;
          ring_count--;
        end else begin
          w.data = ring_mem[(ring_front + ring_count - 1) % Depth];
          ring_count--;
        end
        due_words.push_back(w);
      end
      OP_LIST_FWD, OP_LIST_BWD: begin
        if (ring_count == 0) begin
          w.data   = EmptyWord;
          w.status = STAT_EMPTY;
          due_words.push_back(w);
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            off    = (req.op == OP_LIST_FWD) ? i : ring_count - 1 - i;
            w.data = ring_mem[(ring_front + off) % Depth];
            w.last = (i + 1 == ring_count);
            due_words.push_back(w);
          end
        end
      end
      default: ;  // unused opcodes are dropped silently
    endcase
  endtask

  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(DataW-1){1'b1}}};
      1:       return {1'b1, {(DataW-1){1'b0}}};
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_request(input logic [OpWidth-1:0] op,
                                      input logic [DataW-1:0] value, input int gap);
    deque_req_t req;
    req.op    = op;
    req.value = value;
    req.gap   = gap;
    req.drain = 1'b0;
    request_queue.push_back(req);
  endfunction

  function automatic logic [OpWidth-1:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_PUSH_FRONT;
    if (r < 44) return OP_PUSH_REAR;
    if (r < 60) return OP_POP_FRONT;
    if (r < 76) return OP_POP_REAR;
    if (r < 86) return OP_LIST_FWD;
    if (r < 96) return OP_LIST_BWD;
    return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      idle_cnt = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(active_req);
        requests_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_queue.size() != 0 && idle_cnt >= request_queue[0].gap &&
            !(request_queue[0].drain && due_words.size() != 0)) begin
          active_req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= active_req.value;
          s_axis_tuser  <= {{(TuserW-OpWidth){1'b0}}, active_req.op};
          idle_cnt = 0;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (request_queue.size() != 0) idle_cnt++;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_words.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: data %0d status %0d last %0b",
                     $signed(m_axis_tdata[DataW-1:0]), m_axis_tuser[StatusWidth-1:0],
                     m_axis_tlast);
        end else begin
          if (m_axis_tdata[DataW-1:0] !== due_words[0].data ||
              m_axis_tuser[StatusWidth-1:0] !== due_words[0].status ||
              m_axis_tlast !== due_words[0].last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp data %0d status %0d last %0b, got %0d %0d %0b",
                       due_words[0].data, due_words[0].status, due_words[0].last,
                       $signed(m_axis_tdata[DataW-1:0]), m_axis_tuser[StatusWidth-1:0],
                       m_axis_tlast);
          end
          void'(due_words.pop_front());
        end
        if ($urandom_range(0, 39) == 0) rx_eager = !rx_eager;
        rx_wait = rx_eager ? 0 : $urandom_range(0, 10);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_axis_tready <= (rx_wait == 0) && !hold_off;
    end
  end

  // long receiver hold-off so the deque backs up and stalls its input
  initial begin
    while (requests_taken < 120) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL double_ended_queue");
    $finish;
  end

  initial begin
    int  kind;
    int  len;
    bit  eager;
    bit  first;

    // empty queue corners and ignored opcodes
    add_request(OP_LIST_FWD, rand_word(), 0);
    add_request(OP_LIST_BWD, rand_word(), 2);
    add_request(OP_POP_FRONT, rand_word(), 0);
    add_request(OP_POP_REAR, rand_word(), 1);
    add_request(OP_UNUSED_6, rand_word(), 0);
    add_request(OP_UNUSED_7, '1, 3);
    // extremes at both ends, listed both ways, then drained past empty
    add_request(OP_PUSH_FRONT, {1'b0, {(DataW-1){1'b1}}}, 0);
    add_request(OP_PUSH_REAR, {1'b1, {(DataW-1){1'b0}}}, 0);
    add_request(OP_PUSH_FRONT, '1, 4);
    add_request(OP_PUSH_REAR, '0, 0);
    add_request(OP_LIST_FWD, '0, 0);
    add_request(OP_LIST_BWD, '1, 0);
    add_request(OP_POP_FRONT, '0, 5);
    add_request(OP_POP_REAR, '0, 0);
    add_request(OP_POP_FRONT, '0, 0);
    add_request(OP_POP_REAR, '0, 2);
    add_request(OP_POP_FRONT, '0, 0);
    add_request(OP_PUSH_REAR, 32'h5a5a_a5a5, 0);
    add_request(OP_LIST_BWD, '0, 0);
    add_request(OP_POP_REAR, '0, 0);

    // random part: fill bursts reach the full case, drain bursts the empty case
    first = 1'b1;
    while (request_queue.size() < RandItems) begin
      kind  = first ? 0 : $urandom_range(0, 5);
      eager = ($urandom_range(0, 3) == 0);
      first = 1'b0;
      case (kind)
        0: begin
          len = $urandom_range(14, 20);
          for (int i = 0; i < len; i++)
            add_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR, rand_word(),
                        eager ? 0 : $urandom_range(0, 10));
          add_request($urandom_range(0, 1) ? OP_LIST_FWD : OP_LIST_BWD, rand_word(),
                      eager ? 0 : $urandom_range(0, 10));
        end
        1: begin
          len = $urandom_range(14, 20);
          for (int i = 0; i < len; i++)
            add_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR, rand_word(),
                        eager ? 0 : $urandom_range(0, 10));
        end
        default: begin
          len = $urandom_range(5, 20);
          for (int i = 0; i < len; i++)
            add_request(rand_op(), rand_word(), eager ? 0 : $urandom_range(0, 10));
        end
      endcase
    end
    // sender waits here until every outstanding word has come back
    request_queue[request_queue.size() * 2 / 3].drain = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/dq_pkg.sv
sv/double_ended_queue.sv
dv/double_ended_queue_tb.sv
